[rtl/core/ppte_pkg.sv]
// Shared constants, field positions and the controller-to-datapath command
// type for the piecewise polynomial trajectory evaluator. No dependencies.
`default_nettype none

package ppte_pkg;

    // Fixed field widths of the stream items.
    localparam int COEF_W    = 48;   // Q16.32 coefficients and results
    localparam int TIME_W    = 32;   // unsigned Q8.24 local time
    localparam int TIME_FRAC = 24;
    localparam int SEG_W     = 6;
    localparam int AXIS_W    = 2;
    localparam int IDX_W     = 3;
    localparam int CNT_W     = 4;    // coeffs_in_use register
    localparam int J_W       = 4;    // power counter, covers up to 16 coefficients
    localparam int FACTOR_W  = 8;    // j(j-1) for j up to 15 fits in 8 bits

    // Arithmetic widths of one Horner step.
    localparam int PROD_W = TIME_FRAC + TIME_W;       // 24 x 32 partial product
    localparam int FC_W   = COEF_W + FACTOR_W + 1;    // factor times coefficient
    localparam int SUM_W  = PROD_W + 2;               // rounded product plus term

    localparam int OUT_AXES  = 3;
    localparam int NUM_LANES = 3;                     // position, velocity, acceleration

    // Input tdata layout, lowest bit first.
    localparam int SEG_LSB    = 0;
    localparam int AXIS_LSB   = SEG_LSB + SEG_W;
    localparam int IDX_LSB    = AXIS_LSB + AXIS_W;
    localparam int COEF_LSB   = IDX_LSB + IDX_W;
    localparam int TIME_LSB   = COEF_LSB + COEF_W;
    localparam int IN_TDATA_W = 96;
    localparam int OUT_TDATA_W = NUM_LANES * OUT_AXES * COEF_W;

    // Defaults of the top-level parameters.
    localparam int DEF_MAX_SEGMENTS = 64;
    localparam int DEF_MAX_COEFFS   = 8;
    localparam int DEF_NUM_AXES     = 3;

    localparam logic [CNT_W-1:0] CFG_RESET = 4'd8;

    // Operation codes carried in tuser.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef struct packed {
        logic              load;      // write the offered coefficient
        logic              start;     // capture time and segment, clear lanes
        logic              mag;       // take magnitudes, issue store read
        logic              mul;       // form partial products and scaled term
        logic              rnd;       // round and restore sign
        logic              add;       // add term and saturate
        logic              store;     // move lane results to staging
        logic              out_load;  // copy staging to the output register
        logic [AXIS_W-1:0] axis;
        logic [J_W-1:0]    j;
    } ppte_cmd_t;

endpackage

`default_nettype wire

[rtl/core/ppte_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module ppte_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1536,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/ppte_dpath.sv]
// Datapath of the trajectory evaluator: coefficient store, three Horner
// lanes, staging and output registers. Depends on ppte_pkg and ppte_ram.
`default_nettype none

module ppte_dpath #(
    parameter int MAX_SEGMENTS = ppte_pkg::DEF_MAX_SEGMENTS,
    parameter int MAX_COEFFS   = ppte_pkg::DEF_MAX_COEFFS,
    parameter int NUM_AXES     = ppte_pkg::DEF_NUM_AXES
) (
    input  wire logic                                aclk,
    input  wire ppte_pkg::ppte_cmd_t                 cmd,
    input  wire logic [ppte_pkg::IN_TDATA_W-1:0]     in_data,
    output logic                                     seg_ok,
    output logic      [ppte_pkg::OUT_TDATA_W-1:0]    out_data
);

    localparam int DEPTH   = MAX_SEGMENTS * NUM_AXES * MAX_COEFFS;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW      = ppte_pkg::COEF_W;
    localparam int NL      = ppte_pkg::NUM_LANES;
    localparam int NOUT    = ppte_pkg::NUM_LANES * ppte_pkg::OUT_AXES;
    localparam int LANE_POS = 0;
    localparam int LANE_VEL = 1;
    localparam int LANE_ACC = 2;

    // Input fields.
    logic [ppte_pkg::SEG_W-1:0]  in_seg;
    logic [ppte_pkg::AXIS_W-1:0] in_axis;
    logic [ppte_pkg::IDX_W-1:0]  in_idx;
    logic [CW-1:0]               in_coef;
    logic [ppte_pkg::TIME_W-1:0] in_time;

    assign in_seg  = in_data[ppte_pkg::SEG_LSB  +: ppte_pkg::SEG_W];
    assign in_axis = in_data[ppte_pkg::AXIS_LSB +: ppte_pkg::AXIS_W];
    assign in_idx  = in_data[ppte_pkg::IDX_LSB  +: ppte_pkg::IDX_W];
    assign in_coef = in_data[ppte_pkg::COEF_LSB +: CW];
    assign in_time = in_data[ppte_pkg::TIME_LSB +: ppte_pkg::TIME_W];

    // Store addressing: ((segment * axes + axis) * coefficients + power).
    logic        load_ok;
    logic [31:0] wr_full;
    logic [31:0] rd_full;
    logic [ppte_pkg::SEG_W-1:0]  seg_reg;
    logic [ppte_pkg::TIME_W-1:0] t_reg;
    logic [CW-1:0]               rd_data;

    assign seg_ok  = 32'(in_seg) < MAX_SEGMENTS;
    assign load_ok = seg_ok && (32'(in_axis) < NUM_AXES) && (32'(in_idx) < MAX_COEFFS);
    assign wr_full = (32'(in_seg) * NUM_AXES + 32'(in_axis)) * MAX_COEFFS + 32'(in_idx);
    assign rd_full = (32'(seg_reg) * NUM_AXES + 32'(cmd.axis)) * MAX_COEFFS + 32'(cmd.j);

    ppte_ram #(
        .WIDTH(CW),
        .DEPTH(DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (cmd.load && load_ok),
        .wr_addr (wr_full[AW-1:0]),
        .wr_data (in_coef),
        .rd_en   (cmd.mag),
        .rd_addr (rd_full[AW-1:0]),
        .rd_data (rd_data)
    );

    // Lane registers.
    logic signed [CW-1:0]                    acc_reg [NL];
    logic                                    neg_reg [NL];
    logic        [CW-1:0]                    mag_reg [NL];
    logic        [ppte_pkg::FACTOR_W-1:0]    fac_reg [NL];
    logic        [ppte_pkg::PROD_W-1:0]      plo_reg [NL];
    logic        [ppte_pkg::PROD_W-1:0]      phi_reg [NL];
    logic signed [ppte_pkg::FC_W-1:0]        fc_reg  [NL];
    logic signed [ppte_pkg::SUM_W-1:0]       rs_reg  [NL];
    logic        [CW-1:0]                    stage_reg [NOUT];
    logic        [CW-1:0]                    out_reg   [NOUT];

    // Lane combinational values.
    logic        [CW-1:0]                    mag_val [NL];
    logic        [ppte_pkg::FACTOR_W-1:0]    fac_val [NL];
    logic        [ppte_pkg::PROD_W:0]        lo_rnd  [NL];
    logic        [ppte_pkg::PROD_W:0]        mag_prod [NL];
    logic signed [ppte_pkg::SUM_W-1:0]       rs_val  [NL];
    logic signed [ppte_pkg::SUM_W-1:0]       sum_val [NL];
    logic signed [CW-1:0]                    sat_val [NL];
    logic                                    lane_en [NL];

    always_comb begin
        fac_val[LANE_POS] = ppte_pkg::FACTOR_W'(1);
        fac_val[LANE_VEL] = ppte_pkg::FACTOR_W'(cmd.j);
        fac_val[LANE_ACC] = ppte_pkg::FACTOR_W'(cmd.j)
                          * ppte_pkg::FACTOR_W'(ppte_pkg::J_W'(cmd.j - 1'b1));
        lane_en[LANE_POS] = 1'b1;
        lane_en[LANE_VEL] = cmd.j != '0;
        lane_en[LANE_ACC] = cmd.j > ppte_pkg::J_W'(1);
        for (int l = 0; l < NL; l++) begin
            mag_val[l]  = acc_reg[l][CW-1] ? CW'(-acc_reg[l]) : CW'(acc_reg[l]);
            // Round to nearest, ties away from zero, on the magnitude.
            lo_rnd[l]   = {1'b0, plo_reg[l]}
                        + (ppte_pkg::PROD_W+1)'(1 << (ppte_pkg::TIME_FRAC - 1));
            mag_prod[l] = {1'b0, phi_reg[l]} + (lo_rnd[l] >> ppte_pkg::TIME_FRAC);
            rs_val[l]   = neg_reg[l] ? -$signed({1'b0, mag_prod[l]})
                                     : $signed({1'b0, mag_prod[l]});
            sum_val[l]  = rs_reg[l] + ppte_pkg::SUM_W'(fc_reg[l]);
            // Saturate when the bits above the result's sign disagree with it.
            if (sum_val[l][ppte_pkg::SUM_W-1:CW-1] == '0 ||
                sum_val[l][ppte_pkg::SUM_W-1:CW-1] == '1) begin
                sat_val[l] = CW'(sum_val[l]);
            end else if (sum_val[l][ppte_pkg::SUM_W-1]) begin
                sat_val[l] = {1'b1, {(CW-1){1'b0}}};
            end else begin
                sat_val[l] = {1'b0, {(CW-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            t_reg   <= in_time;
            seg_reg <= in_seg;
        end
        for (int l = 0; l < NL; l++) begin
            if (cmd.start || cmd.store) begin
                acc_reg[l] <= '0;
            end else if (cmd.add && lane_en[l]) begin
                acc_reg[l] <= sat_val[l];
            end
            if (cmd.mag) begin
                neg_reg[l] <= acc_reg[l][CW-1];
                mag_reg[l] <= mag_val[l];
                fac_reg[l] <= fac_val[l];
            end
            if (cmd.mul) begin
                plo_reg[l] <= mag_reg[l][ppte_pkg::TIME_FRAC-1:0] * t_reg;
                phi_reg[l] <= mag_reg[l][CW-1:ppte_pkg::TIME_FRAC] * t_reg;
                fc_reg[l]  <= $signed({1'b0, fac_reg[l]}) * $signed(rd_data);
            end
            if (cmd.rnd) begin
                rs_reg[l] <= rs_val[l];
            end
            for (int ax = 0; ax < ppte_pkg::OUT_AXES; ax++) begin
                if (cmd.start) begin
                    stage_reg[l * ppte_pkg::OUT_AXES + ax] <= '0;
                end else if (cmd.store && cmd.axis == ppte_pkg::AXIS_W'(ax)) begin
                    stage_reg[l * ppte_pkg::OUT_AXES + ax] <= acc_reg[l];
                end
            end
        end
        if (cmd.out_load) begin
            out_reg <= stage_reg;
        end
    end

    always_comb begin
        for (int k = 0; k < NOUT; k++) begin
            out_data[k * CW +: CW] = out_reg[k];
        end
    end

endmodule

`default_nettype wire

[rtl/core/ppte_ctrl.sv]
// Controller of the trajectory evaluator: handshakes, the coefficient count
// register and the Horner sequencer. Depends on ppte_pkg.
`default_nettype none

module ppte_ctrl #(
    parameter int MAX_COEFFS = ppte_pkg::DEF_MAX_COEFFS,
    parameter int NUM_AXES   = ppte_pkg::DEF_NUM_AXES
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic                         s_op,
    input  wire logic                         seg_ok,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [ppte_pkg::CNT_W-1:0]   cfg_data,
    output ppte_pkg::ppte_cmd_t               cmd
);

    localparam int JW = ppte_pkg::J_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAG,
        S_MUL,
        S_RND,
        S_ADD,
        S_STORE,
        S_DONE
    } state_t;

    state_t                        state_reg, state_next;
    logic [JW-1:0]                 j_reg, j_next;
    logic [ppte_pkg::AXIS_W-1:0]   axis_reg, axis_next;
    logic [ppte_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                          m_valid_reg, m_valid_next;
    logic [JW:0]                   n_used;
    logic [JW-1:0]                 j_start;

    // A count of zero is used as one, and one above the store as the maximum.
    always_comb begin
        if (cnt_reg == '0) begin
            n_used = (JW+1)'(1);
        end else if (32'(cnt_reg) > MAX_COEFFS) begin
            n_used = (JW+1)'(MAX_COEFFS);
        end else begin
            n_used = (JW+1)'(cnt_reg);
        end
        j_start = JW'(n_used - 1'b1);
    end

    assign s_tready  = state_reg == S_IDLE;
    assign m_tvalid  = m_valid_reg;
    assign cfg_ready = 1'b1;

    always_comb begin
        state_next   = state_reg;
        j_next       = j_reg;
        axis_next    = axis_reg;
        cnt_next     = cfg_valid ? cfg_data : cnt_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd          = '0;
        cmd.axis     = axis_reg;
        cmd.j        = j_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_op == ppte_pkg::OP_EVAL) begin
                        cmd.start  = 1'b1;
                        j_next     = j_start;
                        axis_next  = '0;
                        state_next = seg_ok ? S_MAG : S_DONE;
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            S_MAG: begin
                cmd.mag    = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_RND;
            end
            S_RND: begin
                cmd.rnd    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD: begin
                cmd.add = 1'b1;
                if (j_reg == '0) begin
                    state_next = S_STORE;
                end else begin
                    j_next     = j_reg - 1'b1;
                    state_next = S_MAG;
                end
            end
            S_STORE: begin
                cmd.store = 1'b1;
                if (32'(axis_reg) >= NUM_AXES - 1) begin
                    state_next = S_DONE;
                end else begin
                    axis_next  = axis_reg + 1'b1;
                    j_next     = j_start;
                    state_next = S_MAG;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            j_reg       <= '0;
            axis_reg    <= '0;
            cnt_reg     <= ppte_pkg::CFG_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            j_reg       <= j_next;
            axis_reg    <= axis_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_eval_enters_loop: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.start && seg_ok) |=> (state_reg == S_MAG))
        else $error("evaluate of a stored segment did not enter the Horner loop");

    a_bad_seg_skips: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.start && !seg_ok) |=> (state_reg == S_DONE))
        else $error("evaluate of an absent segment did not go straight to the result");

    a_axis_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(axis_reg) < NUM_AXES)
        else $error("axis counter ran past the configured axes");

    a_valid_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the completion state");

endmodule

`default_nettype wire

[rtl/core/piecewise_poly_trajectory_eval_top.sv]
// Top level of the piecewise polynomial trajectory evaluator.
// Depends on ppte_pkg, ppte_ctrl, ppte_dpath and ppte_ram.
//
//  Channel | Direction | Handshake          | Contents
//  --------+-----------+--------------------+---------------------------------------
//  s_      | in        | s_tvalid/s_tready  | load one coefficient or evaluate (tuser)
//  m_      | out       | m_tvalid/m_tready  | pos, vel, acc for x, y, z
//  cfg_    | in        | cfg_valid/cfg_ready| coeffs_in_use
//
// A load item is written straight into the coefficient RAM. An evaluate
// item runs the Horner step (magnitude, multiply, round, add) once per
// coefficient in use for each axis in turn, and all three lanes share the
// step and the single RAM read port. An evaluate item for a segment beyond
// the store skips the Horner loop and goes straight to the result.
// Reset clears only control state; the coefficient RAM is not cleared and
// holds nothing meaningful until loaded, so there is no clearing pass.
// A finished result waits in the output register while further items are
// accepted; only the next evaluate result waits for that register to empty.
`default_nettype none

module piecewise_poly_trajectory_eval_top #(
    parameter int MAX_SEGMENTS = ppte_pkg::DEF_MAX_SEGMENTS,
    parameter int MAX_COEFFS   = ppte_pkg::DEF_MAX_COEFFS,
    parameter int NUM_AXES     = ppte_pkg::DEF_NUM_AXES
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    // Input items.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // segment[5:0], axis[7:6], coef_index[10:8], coef_value[58:11],
    // sample_time[90:59], zero padding[95:91]
    input  wire logic [ppte_pkg::IN_TDATA_W-1:0]   s_tdata,
    // op[0]: 0 load one coefficient, 1 evaluate
    input  wire logic                              s_tuser,

    // Result items.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // pos_x[47:0], pos_y[95:48], pos_z[143:96], vel_x[191:144],
    // vel_y[239:192], vel_z[287:240], acc_x[335:288], acc_y[383:336],
    // acc_z[431:384]
    output logic      [ppte_pkg::OUT_TDATA_W-1:0]  m_tdata,

    // Configuration: coeffs_in_use.
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ppte_pkg::CNT_W-1:0]        cfg_data
);

    ppte_pkg::ppte_cmd_t cmd;
    logic                seg_ok;

    // The controller sequences the work; the datapath holds all payload.
    ppte_ctrl #(
        .MAX_COEFFS (MAX_COEFFS),
        .NUM_AXES   (NUM_AXES)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_op      (s_tuser),
        .seg_ok    (seg_ok),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd)
    );

    ppte_dpath #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .MAX_COEFFS   (MAX_COEFFS),
        .NUM_AXES     (NUM_AXES)
    ) u_dpath (
        .aclk     (aclk),
        .cmd      (cmd),
        .in_data  (s_tdata),
        .seg_ok   (seg_ok),
        .out_data (m_tdata)
    );

endmodule

`default_nettype wire

[test/piecewise_poly_trajectory_eval_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the piecewise polynomial trajectory evaluator.
// Depends on ppte_pkg and piecewise_poly_trajectory_eval_top, nothing else.

module piecewise_poly_trajectory_eval_top_tb;
    import ppte_pkg::*;

    localparam int SEGMENTS = DEF_MAX_SEGMENTS;
    localparam int COEFFS   = DEF_MAX_COEFFS;
    localparam int AXES     = DEF_NUM_AXES;
    localparam int FIELDS   = NUM_LANES * OUT_AXES;

    // Axis codes of a load item; the last one lies beyond the store.
    localparam int AXIS_X    = 0;
    localparam int AXIS_Y    = 1;
    localparam int AXIS_Z    = 2;
    localparam int AXIS_NONE = 3;

    // Derivative order of each lane of the result.
    localparam int LANE_POS = 0;
    localparam int LANE_VEL = 1;
    localparam int LANE_ACC = 2;

    localparam logic [COEF_W-1:0] COEF_TOP    = 48'h7FFF_FFFF_FFFF;
    localparam logic [COEF_W-1:0] COEF_BOTTOM = 48'h8000_0000_0000;
    localparam longint            SAT_HIGH    = (longint'(1) <<< (COEF_W - 1)) - 1;
    localparam longint            SAT_LOW     = -(longint'(1) <<< (COEF_W - 1));
    localparam logic [TIME_W-1:0] ONE_SECOND  = 32'h0100_0000;
    localparam logic [TIME_W-1:0] HALF_SECOND = 32'h0080_0000;

    localparam int SETTLE_CYCLES  = 8;
    localparam int END_CYCLES     = 120;
    localparam int HOLD_CYCLES    = 1200;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS    = 78;
    localparam int MAX_REPORTS    = 60;

    // One result item: field k sits at bits [48k+47:48k], in the order of field_names.
    typedef logic [FIELDS-1:0][COEF_W-1:0] traj_sample_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tuser   = OP_LOAD;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CNT_W-1:0]       cfg_data  = '0;

    // Mirror of the coefficient RAM, with a flag per entry once it has been loaded.
    longint           coef_image  [SEGMENTS][AXES][COEFFS];
    bit               coef_loaded [SEGMENTS][AXES][COEFFS];
    logic [CNT_W-1:0] coeff_count = CFG_RESET;
    traj_sample_t     pending_samples[$];

    string field_names [FIELDS] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z",
                                    "acc_x", "acc_y", "acc_z"};

    int error_count     = 0;
    int items_sent      = 0;
    int loads_sent      = 0;
    int evals_sent      = 0;
    int results_checked = 0;
    int send_gap_pct    = 0;
    int recv_stall_pct  = 0;
    int hold_requests   = 0;
    int holds_served    = 0;
    int hold_left       = 0;
    int quiet_cycles    = 0;

    piecewise_poly_trajectory_eval_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Prediction of the arithmetic.
    // ------------------------------------------------------------------

    // A count of zero is taken as one, anything above the store depth as the depth.
    function automatic int used_count(logic [CNT_W-1:0] v);
        if (v == 0) return 1;
        if (v > COEFFS) return COEFFS;
        return int'(v);
    endfunction

    function automatic longint clamp48(longint v);
        if (v > SAT_HIGH) return SAT_HIGH;
        if (v < SAT_LOW) return SAT_LOW;
        return v;
    endfunction

    // a * t with t in Q8.24, rounded to nearest with ties away from zero. The
    // product is split so that no partial result overflows 64 bits.
    function automatic longint time_scale_round(longint a, longint unsigned t);
        bit              neg;
        longint unsigned mag;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned r;
        neg = (a < 0);
        mag = neg ? -a : a;
        hi  = mag >> TIME_FRAC;
        lo  = mag & ((64'd1 << TIME_FRAC) - 1);
        r   = hi * t + ((lo * t + (64'd1 << (TIME_FRAC - 1))) >> TIME_FRAC);
        return neg ? -longint'(r) : longint'(r);
    endfunction

    // Horner's rule over powers n-1 down to the derivative order, saturating at every step.
    function automatic longint horner_axis(int seg, int ax, int n, int deriv,
                                           longint unsigned t);
        longint acc;
        longint factor;
        acc = 0;
        for (int p = n - 1; p >= deriv; p--) begin
            if (deriv == LANE_POS) factor = 1;
            else if (deriv == LANE_VEL) factor = p;
            else factor = p * (p - 1);
            acc = clamp48(time_scale_round(acc, t) + factor * coef_image[seg][ax][p]);
        end
        return acc;
    endfunction

    function automatic traj_sample_t predict_trajectory(int seg, longint unsigned t);
        traj_sample_t sample;
        longint       v;
        int           n;
        n = used_count(coeff_count);
        for (int lane = 0; lane < NUM_LANES; lane++) begin
            for (int ax = 0; ax < OUT_AXES; ax++) begin
                v = horner_axis(seg, ax, n, lane, t);
                sample[lane * OUT_AXES + ax] = v[COEF_W-1:0];
            end
        end
        return sample;
    endfunction

    // True once every coefficient that an evaluation would read has been loaded.
    function automatic bit segment_ready(int seg, int n);
        for (int ax = 0; ax < AXES; ax++)
            for (int idx = 0; idx < n; idx++)
                if (!coef_loaded[seg][ax][idx]) return 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Random values, weighted towards magnitudes that keep most results
    // inside the Q16.32 range while still reaching saturation now and then.
    // ------------------------------------------------------------------

    function automatic logic [COEF_W-1:0] random_coef();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        case ($urandom_range(5, 0))
            0: return r[COEF_W-1:0];
            1: begin
                case ($urandom_range(3, 0))
                    0: return COEF_TOP;
                    1: return COEF_BOTTOM;
                    2: return '0;
                    default: return '1;
                endcase
            end
            2: return COEF_W'($signed(r[40:0]));
            default: return COEF_W'($signed(r[34:0]));
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] random_time();
        case ($urandom_range(5, 0))
            0: return $urandom();
            1: begin
                case ($urandom_range(3, 0))
                    0: return '0;
                    1: return '1;
                    2: return ONE_SECOND;
                    default: return HALF_SECOND;
                endcase
            end
            default: return TIME_W'($urandom_range(32'h0200_0000, 0));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input side. Every task is entered and left at a rising clock edge.
    // ------------------------------------------------------------------

    // Offers one item, with random idle cycles beforehand, and waits until it
    // is taken. The prediction is made at the edge where the item is accepted.
    task automatic send_item(logic op, int seg, int ax, int idx,
                             logic [COEF_W-1:0] coef, logic [TIME_W-1:0] t);
        while ($urandom_range(99, 0) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= IN_TDATA_W'({t, coef, IDX_W'(idx), AXIS_W'(ax), SEG_W'(seg)});
        do @(posedge aclk); while (!s_tready);
        if (op == OP_LOAD) begin
            // A load to the axis code beyond the store is dropped by the block.
            if (ax < AXES) begin
                coef_image[seg][ax][idx]  = longint'($signed(coef));
                coef_loaded[seg][ax][idx] = 1'b1;
                items_sent++;
                loads_sent++;
            end
        end else begin
            pending_samples.push_back(predict_trajectory(seg, t));
            items_sent++;
            evals_sent++;
        end
    endtask

    task automatic load_coef(int seg, int ax, int idx, logic [COEF_W-1:0] value);
        send_item(OP_LOAD, seg, ax, idx, value, $urandom());
    endtask

    // The load fields of an evaluate item are don't-care and carry random bits.
    task automatic evaluate(int seg, logic [TIME_W-1:0] t);
        send_item(OP_EVAL, seg, $urandom_range(3, 0), $urandom_range(COEFFS - 1, 0),
                  random_coef(), t);
    endtask

    // Stops offering, waits for every outstanding result, then lets a trailing
    // load finish so that the block is idle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_coeff_count(logic [CNT_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        coeff_count  = value;
    endtask

    // ------------------------------------------------------------------
    // Output side.
    // ------------------------------------------------------------------

    // Receiver: random stalls, or a long hold-off whenever one is requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    task automatic check_sample(traj_sample_t got);
        traj_sample_t want;
        if (pending_samples.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: result arrived with none expected: %h", $time, got);
            return;
        end
        want = pending_samples.pop_front();
        results_checked++;
        for (int k = 0; k < FIELDS; k++) begin
            if (got[k] !== want[k]) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: %s expected %h actual %h", $time, field_names[k],
                             want[k], got[k]);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_sample(m_tdata);
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, no handshake for %0d cycles", $time,
                     quiet_cycles);
            $display("piecewise_poly_trajectory_eval_top_tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Three coefficients per axis on the top segment: x at the positive limit
    // and y at the negative limit so that every lane saturates at long times,
    // and z holding a tiny polynomial whose Horner steps land exactly on
    // rounding ties of both signs at half a second. A load to the axis code
    // beyond the store is sent where a wrongly decoded address would alias
    // onto x of the top segment, and must leave the results untouched.
    task automatic test_extremes_and_rounding();
        set_coeff_count(4'd3);
        for (int idx = 0; idx < 3; idx++) begin
            load_coef(SEGMENTS - 1, AXIS_X, idx, COEF_TOP);
            load_coef(SEGMENTS - 1, AXIS_Y, idx, COEF_BOTTOM);
        end
        load_coef(SEGMENTS - 1, AXIS_Z, 0, 48'd5);
        load_coef(SEGMENTS - 1, AXIS_Z, 1, 48'd2);
        load_coef(SEGMENTS - 1, AXIS_Z, 2, '1);
        load_coef(SEGMENTS - 2, AXIS_NONE, 0, 48'h1234_5678_9ABC);
        evaluate(SEGMENTS - 1, '0);
        evaluate(SEGMENTS - 1, '1);
        evaluate(SEGMENTS - 1, ONE_SECOND);
        evaluate(SEGMENTS - 1, HALF_SECOND);
    endtask

    // A count of zero must behave as one coefficient: constant position,
    // velocity and acceleration both zero. Segment zero gets its constants here.
    task automatic test_zero_count();
        set_coeff_count(4'd0);
        load_coef(0, AXIS_X, 0, COEF_BOTTOM);
        load_coef(0, AXIS_Y, 0, COEF_TOP);
        load_coef(0, AXIS_Z, 0, random_coef());
        evaluate(0, '1);
        evaluate(SEGMENTS - 1, random_time());
    endtask

    // The receiver holds off for a long stretch while evaluations keep coming,
    // so the output register and then the input fill and the block stalls.
    // Afterwards the sender waits for every result before going on.
    task automatic test_output_backpressure();
        hold_requests++;
        for (int k = 0; k < 12; k++) evaluate((k % 2 == 0) ? 0 : SEGMENTS - 1, random_time());
        wait_idle();
    endtask

    // One setting of the coefficient count. Most of the traffic is complete
    // segments loaded in a shuffled order and then sampled several times, or
    // touch-ups of a segment already complete; the rest is stray loads
    // anywhere (axis code beyond the store included) and lone evaluations.
    task automatic run_random_phase(logic [CNT_W-1:0] count);
        int slots [AXES*COEFFS];
        int n;
        int seg;
        int start;
        int pick;
        int total;
        int j;
        int tmp;
        set_coeff_count(count);
        n     = used_count(count);
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS) begin
            pick = $urandom_range(99, 0);
            seg  = $urandom_range(SEGMENTS - 1, 0);
            if (pick < 65) begin
                if (segment_ready(seg, n) && $urandom_range(1, 0) == 1) begin
                    repeat ($urandom_range(4, 1))
                        load_coef(seg, $urandom_range(AXES - 1, 0), $urandom_range(n - 1, 0),
                                  random_coef());
                end else begin
                    total = AXES * n;
                    for (int k = 0; k < total; k++) slots[k] = k;
                    for (int k = total - 1; k > 0; k--) begin
                        j        = $urandom_range(k, 0);
                        tmp      = slots[k];
                        slots[k] = slots[j];
                        slots[j] = tmp;
                    end
                    for (int k = 0; k < total; k++)
                        load_coef(seg, slots[k] / n, slots[k] % n, random_coef());
                end
                repeat ($urandom_range(6, 2)) evaluate(seg, random_time());
            end else if (pick < 85) begin
                // Walk on from a random start to the next complete segment, if any.
                for (int k = 0; k < SEGMENTS && !segment_ready(seg, n); k++)
                    seg = (seg + 1) % SEGMENTS;
                if (segment_ready(seg, n)) evaluate(seg, random_time());
            end else begin
                load_coef(seg, $urandom_range(AXIS_NONE, 0), $urandom_range(COEFFS - 1, 0),
                          random_coef());
            end
        end
    endtask

    task automatic test_random_traffic(int gap_pct, int stall_pct, logic [CNT_W-1:0] c0,
                                       logic [CNT_W-1:0] c1, logic [CNT_W-1:0] c2);
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        run_random_phase(c0);
        run_random_phase(c1);
        run_random_phase(c2);
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------

    initial begin
        send_gap_pct   = 8;
        recv_stall_pct = 47;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extremes_and_rounding();
        test_zero_count();
        test_output_backpressure();

        // Sender idling lightly and receiver heavily, then the reverse, then
        // full rate both ways; the count runs through both clamped ends.
        test_random_traffic(8, 47, 4'd8, 4'd1, 4'd15);
        test_random_traffic(47, 8, 4'd0, 4'd3, 4'd9);
        test_random_traffic(0, 0, CNT_W'($urandom_range(15, 0)), 4'd2, 4'd8);

        wait_idle();
        repeat (END_CYCLES) @(posedge aclk);
        if (pending_samples.size() != 0) begin
            error_count++;
            $display("%0t: %0d expected results never arrived", $time,
                     pending_samples.size());
        end

        $display("Run sent %0d coefficient loads and %0d evaluations; %0d results checked.",
                 loads_sent, evals_sent, results_checked);
        $display("Counts 0 to 15 incl. clamping, saturation, rounding ties and output stalls.");
        if (error_count == 0) begin
            $display("piecewise_poly_trajectory_eval_top_tb: clean");
        end else begin
            $display("piecewise_poly_trajectory_eval_top_tb: errors");
        end
        $finish;
    end

endmodule
